// ----- hdl/tile_constraint_propagator_top_defines.svh -----
// Assertion macros for the tile constraint propagator.
`ifndef TILE_CONSTRAINT_PROPAGATOR_TOP_DEFINES_SVH
`define TILE_CONSTRAINT_PROPAGATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TCP_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("tcp assertion failed");
`define TCP_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("tcp assertion failed");
`else
`define TCP_ASSERT(lbl, expr)
`define TCP_ASSERT_IMP(lbl, pre, post)
`endif
`endif

// ----- hdl/tcp_pkg.sv -----
`timescale 1ns / 1ps
package tcp_pkg;
	localparam int TileCount = 16;
	localparam int MaxCells  = 1024;
	localparam int CellW     = $clog2(MaxCells);
	localparam int CntW      = CellW + 1;
	localparam int DirCount  = 6;
	localparam int DimW      = 11;
	localparam int PlaneW    = 2 * DimW;
	localparam int SumW      = PlaneW + 1;
	localparam int StepW     = $clog2(CellW + 1);

	typedef logic [TileCount-1:0] tmask_t;
	typedef logic [CellW-1:0] cell_t;
	typedef logic [DimW-1:0] dim_t;

	typedef enum logic [1:0] {REQ_RULE, REQ_SET, REQ_RESTRICT, REQ_READ} req_t;
	typedef enum logic [1:0] {ST_OK, ST_CONTRA, ST_OUTSIDE} status_t;
	typedef enum logic [1:0] {CFG_WIDTH, CFG_HEIGHT, CFG_DEPTH} cfg_idx_t;
	typedef enum logic [2:0] {
		DIR_ZN, DIR_ZP, DIR_XN, DIR_XP, DIR_YN, DIR_YP
	} dir_t;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_RD, S_EVAL, S_POP, S_POPW, S_DIV1, S_DIV2,
		S_NB, S_NBW, S_FLUSH_RD, S_FLUSH_WR, S_FINAL, S_FINALW, S_RESULT
	} state_t;

	typedef struct packed {
		logic  start;
		cell_t dividend;
		dim_t  divisor;
	} div_req_t;

	typedef struct packed {
		logic  done;
		cell_t quot;
		cell_t rem;
	} div_rsp_t;

	function automatic logic [4:0] popcount(input tmask_t v);
		logic [4:0] n;
		n = '0;
		for (int i = 0; i < TileCount; i++) begin
			n = n + 5'(v[i]);
		end
		return n;
	endfunction
endpackage

// ----- hdl/tcp_intf.sv -----
`timescale 1ns / 1ps
interface tcp_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [9:0] cell_req;
	logic [2:0] dir;
	logic [3:0] tile;
	logic [15:0] mask;
	modport source (output valid, req_type, cell_req, dir, tile, mask, input ready);
	modport sink (input valid, req_type, cell_req, dir, tile, mask, output ready);
endinterface

interface tcp_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] domain;
	logic [4:0]  tile_count;
	modport source (output valid, status, domain, tile_count, input ready);
	modport sink (input valid, status, domain, tile_count, output ready);
endinterface

interface tcp_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [10:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/tile_constraint_propagator_top.sv -----
`timescale 1ns / 1ps
// channel  dir  payload                              handshake
// cfg      in   index, data                          valid/ready
// req      in   req_type, cell_req, dir, tile, mask  valid/ready
// rsp      out  status, domain, tile_count           valid/ready
// One word at a time: rule, set and read words need no propagation, nor does a
// restrict that removes no tile; else each queued cell takes two divides
// for the cell coordinates, then each neighbor goes through the domain RAM.
// After reset a pass over every entry clears the pending RAM; req.ready stays low.
// After a cfg write req.ready stays low while the cell count settles.
// A stalled rsp holds the next result in the state machine.
`include "tile_constraint_propagator_top_defines.svh"
module tile_constraint_propagator_top (
	input logic   clk,
	input logic   arst_n,
	tcp_cfg_if.sink   cfg,
	tcp_req_if.sink   req,
	tcp_rsp_if.source rsp
);
	tcp_pkg::state_t  state_q, state_d;
	tcp_pkg::dim_t    w_q, h_q, d_q;
	logic [tcp_pkg::PlaneW-1:0] plane_q;
	logic [tcp_pkg::PlaneW+tcp_pkg::DimW-1:0] vol;
	logic [tcp_pkg::CntW-1:0]   ncells_q;
	logic [1:0]       settle_q;
	logic             flag_q, flag_d;
	logic [tcp_pkg::CntW-1:0]   count_q, count_d;
	tcp_pkg::cell_t   head_q, head_d, clr_q;
	tcp_pkg::req_t    type_q;
	tcp_pkg::cell_t   cell_q, c_q, x_q, q1_q, y_q, z_q;
	tcp_pkg::tmask_t  mask_q, cur_q;
	logic [2:0]       k_q, k_d;
	tcp_pkg::tmask_t  res_dom_q, res_dom_d;
	tcp_pkg::status_t res_st_q, res_st_d;
	logic             rsp_valid_q;
	tcp_pkg::tmask_t  rsp_dom_q;
	tcp_pkg::status_t rsp_st_q;

	logic             dom_we, pend_we, pend_wdata, q_we, rule_we, pend_rdata;
	tcp_pkg::cell_t   dom_waddr, dom_raddr, pend_waddr, q_waddr, q_rdata, tail;
	tcp_pkg::tmask_t  dom_wdata, dom_rdata, keep;
	logic [2:0]       rule_rdir;
	logic [tcp_pkg::TileCount-1:0][tcp_pkg::TileCount-1:0] rule_row;
	tcp_pkg::div_req_t div_req;
	tcp_pkg::div_rsp_t div_rsp;
	logic             nb_ok, accept, out_free;
	tcp_pkg::cell_t   nb_n;
	logic [2:0]       nb_dir;
	logic [tcp_pkg::SumW-1:0] c_ext, w_ext, p_ext, n_ext;
	tcp_pkg::tmask_t  nw;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == tcp_pkg::S_IDLE) && (settle_q == '0);
	assign cfg.ready = 1'b1;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign tail = head_q + count_q[tcp_pkg::CellW-1:0];
	assign vol = plane_q * d_q;

	// config and derived grid size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q      <= tcp_pkg::DimW'(8);
			h_q      <= tcp_pkg::DimW'(4);
			d_q      <= tcp_pkg::DimW'(8);
			plane_q  <= tcp_pkg::PlaneW'(32);
			ncells_q <= tcp_pkg::CntW'(256);
			settle_q <= '0;
		end else begin
			plane_q <= tcp_pkg::PlaneW'(w_q * h_q);
			if (vol > (tcp_pkg::PlaneW + tcp_pkg::DimW)'(tcp_pkg::MaxCells)) begin
				ncells_q <= tcp_pkg::CntW'(tcp_pkg::MaxCells);
			end else begin
				ncells_q <= vol[tcp_pkg::CntW-1:0];
			end
			if (cfg.valid && cfg.ready) begin
				settle_q <= 2'd2;
				unique case (cfg.index)
					tcp_pkg::CFG_WIDTH:  w_q <= cfg.data;
					tcp_pkg::CFG_HEIGHT: h_q <= cfg.data;
					tcp_pkg::CFG_DEPTH:  d_q <= cfg.data;
					default: ;
				endcase
			end else if (settle_q != '0) begin
				settle_q <= settle_q - 1'b1;
			end
		end
	end

	// neighbor select
	always_comb begin
		c_ext = tcp_pkg::SumW'(c_q);
		w_ext = tcp_pkg::SumW'(w_q);
		p_ext = tcp_pkg::SumW'(plane_q);
		nb_ok = 1'b0;
		n_ext = c_ext;
		nb_dir = tcp_pkg::DIR_XN;
		case (k_q)
			3'd0: begin
				nb_ok = x_q != '0;
				n_ext = c_ext - 1'b1;
				nb_dir = tcp_pkg::DIR_XN;
			end
			3'd1: begin
				nb_ok = (tcp_pkg::DimW'(x_q) + 1'b1 < w_q) &&
					(c_ext + 1'b1 < tcp_pkg::SumW'(ncells_q));
				n_ext = c_ext + 1'b1;
				nb_dir = tcp_pkg::DIR_XP;
			end
			3'd2: begin
				nb_ok = y_q != '0;
				n_ext = c_ext - w_ext;
				nb_dir = tcp_pkg::DIR_YN;
			end
			3'd3: begin
				nb_ok = (tcp_pkg::DimW'(y_q) + 1'b1 < h_q) &&
					(c_ext + w_ext < tcp_pkg::SumW'(ncells_q));
				n_ext = c_ext + w_ext;
				nb_dir = tcp_pkg::DIR_YP;
			end
			3'd4: begin
				nb_ok = z_q != '0;
				n_ext = c_ext - p_ext;
				nb_dir = tcp_pkg::DIR_ZN;
			end
			3'd5: begin
				nb_ok = (tcp_pkg::DimW'(z_q) + 1'b1 < d_q) &&
					(c_ext + p_ext < tcp_pkg::SumW'(ncells_q));
				n_ext = c_ext + p_ext;
				nb_dir = tcp_pkg::DIR_ZP;
			end
			default: ;
		endcase
		nb_n = n_ext[tcp_pkg::CellW-1:0];
		for (int t = 0; t < tcp_pkg::TileCount; t++) begin
			keep[t] = dom_rdata[t] && ((rule_row[t] & cur_q) != '0);
		end
		nw = dom_rdata & mask_q;
	end

	always_comb begin
		state_d = state_q;
		flag_d = flag_q;
		count_d = count_q;
		head_d = head_q;
		k_d = k_q;
		res_dom_d = res_dom_q;
		res_st_d = res_st_q;
		dom_we = 1'b0;
		dom_waddr = nb_n;
		dom_wdata = keep;
		dom_raddr = cell_q;
		pend_we = 1'b0;
		pend_waddr = nb_n;
		pend_wdata = 1'b1;
		q_we = 1'b0;
		q_waddr = tail;
		rule_we = 1'b0;
		rule_rdir = nb_dir;
		div_req = '0;
		unique case (state_q)
			tcp_pkg::S_CLEAR: begin
				pend_we = 1'b1;
				pend_waddr = clr_q;
				pend_wdata = 1'b0;
				if (clr_q == '1) begin
					state_d = tcp_pkg::S_IDLE;
				end
			end
			tcp_pkg::S_IDLE: begin
				if (accept) begin
					res_dom_d = '0;
					state_d = tcp_pkg::S_RESULT;
					if (tcp_pkg::req_t'(req.req_type) == tcp_pkg::REQ_RULE) begin
						rule_we = req.dir < 3'(tcp_pkg::DirCount);
						res_st_d = flag_q ? tcp_pkg::ST_CONTRA : tcp_pkg::ST_OK;
					end else begin
						if (tcp_pkg::req_t'(req.req_type) == tcp_pkg::REQ_SET) begin
							flag_d = 1'b0;
						end
						if (tcp_pkg::CntW'(req.cell_req) >= ncells_q) begin
							res_st_d = tcp_pkg::ST_OUTSIDE;
						end else if (tcp_pkg::req_t'(req.req_type) == tcp_pkg::REQ_SET) begin
							dom_we = 1'b1;
							dom_waddr = req.cell_req;
							dom_wdata = req.mask;
							res_dom_d = req.mask;
							res_st_d = tcp_pkg::ST_OK;
						end else begin
							state_d = tcp_pkg::S_RD;
						end
					end
				end
			end
			tcp_pkg::S_RD: begin
				state_d = tcp_pkg::S_EVAL;
			end
			tcp_pkg::S_EVAL: begin
				res_dom_d = dom_rdata;
				res_st_d = flag_q ? tcp_pkg::ST_CONTRA : tcp_pkg::ST_OK;
				state_d = tcp_pkg::S_RESULT;
				if (type_q == tcp_pkg::REQ_RESTRICT && !flag_q && nw != dom_rdata) begin
					dom_we = 1'b1;
					dom_waddr = cell_q;
					dom_wdata = nw;
					res_dom_d = nw;
					if (nw == '0) begin
						flag_d = 1'b1;
						res_st_d = tcp_pkg::ST_CONTRA;
					end else begin
						pend_we = 1'b1;
						pend_waddr = cell_q;
						q_we = 1'b1;
						count_d = count_q + 1'b1;
						state_d = tcp_pkg::S_POP;
					end
				end
			end
			tcp_pkg::S_POP: begin
				state_d = (count_q == '0) ? tcp_pkg::S_FINAL : tcp_pkg::S_POPW;
			end
			tcp_pkg::S_POPW: begin
				pend_we = 1'b1;
				pend_waddr = q_rdata;
				pend_wdata = 1'b0;
				head_d = head_q + 1'b1;
				count_d = count_q - 1'b1;
				div_req.start = 1'b1;
				div_req.dividend = q_rdata;
				div_req.divisor = w_q;
				state_d = tcp_pkg::S_DIV1;
			end
			tcp_pkg::S_DIV1: begin
				dom_raddr = c_q;
				if (div_rsp.done) begin
					div_req.start = 1'b1;
					div_req.dividend = div_rsp.quot;
					div_req.divisor = h_q;
					state_d = tcp_pkg::S_DIV2;
				end
			end
			tcp_pkg::S_DIV2: begin
				if (div_rsp.done) begin
					k_d = '0;
					state_d = tcp_pkg::S_NB;
				end
			end
			tcp_pkg::S_NB: begin
				dom_raddr = nb_n;
				if (nb_ok) begin
					state_d = tcp_pkg::S_NBW;
				end else if (k_q == 3'(tcp_pkg::DirCount - 1)) begin
					state_d = tcp_pkg::S_POP;
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			tcp_pkg::S_NBW: begin
				k_d = k_q + 1'b1;
				state_d = (k_q == 3'(tcp_pkg::DirCount - 1)) ? tcp_pkg::S_POP : tcp_pkg::S_NB;
				if (keep != dom_rdata) begin
					dom_we = 1'b1;
					if (keep == '0) begin
						flag_d = 1'b1;
						state_d = tcp_pkg::S_FLUSH_RD;
					end else if (!pend_rdata &&
						count_q < tcp_pkg::CntW'(tcp_pkg::MaxCells)) begin
						pend_we = 1'b1;
						q_we = 1'b1;
						count_d = count_q + 1'b1;
					end
				end
			end
			tcp_pkg::S_FLUSH_RD: begin
				state_d = (count_q == '0) ? tcp_pkg::S_FINAL : tcp_pkg::S_FLUSH_WR;
			end
			tcp_pkg::S_FLUSH_WR: begin
				pend_we = 1'b1;
				pend_waddr = q_rdata;
				pend_wdata = 1'b0;
				head_d = head_q + 1'b1;
				count_d = count_q - 1'b1;
				state_d = tcp_pkg::S_FLUSH_RD;
			end
			tcp_pkg::S_FINAL: begin
				state_d = tcp_pkg::S_FINALW;
			end
			tcp_pkg::S_FINALW: begin
				res_dom_d = dom_rdata;
				res_st_d = flag_q ? tcp_pkg::ST_CONTRA : tcp_pkg::ST_OK;
				state_d = tcp_pkg::S_RESULT;
			end
			tcp_pkg::S_RESULT: begin
				if (out_free) begin
					state_d = tcp_pkg::S_IDLE;
				end
			end
			default: state_d = tcp_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcp_pkg::S_CLEAR;
			flag_q <= 1'b0;
			count_q <= '0;
			head_q <= '0;
			clr_q <= '0;
			k_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			flag_q <= flag_d;
			count_q <= count_d;
			head_q <= head_d;
			k_q <= k_d;
			clr_q <= clr_q + 1'b1;
			if (state_q == tcp_pkg::S_RESULT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_dom_q <= res_dom_d;
		res_st_q <= res_st_d;
		if (accept) begin
			type_q <= tcp_pkg::req_t'(req.req_type);
			cell_q <= req.cell_req;
			mask_q <= req.mask;
		end
		if (state_q == tcp_pkg::S_POPW) begin
			c_q <= q_rdata;
		end
		if (state_q == tcp_pkg::S_DIV1 && div_rsp.done) begin
			x_q <= div_rsp.rem;
			q1_q <= div_rsp.quot;
			cur_q <= dom_rdata;
		end
		if (state_q == tcp_pkg::S_DIV2 && div_rsp.done) begin
			y_q <= div_rsp.rem;
			z_q <= div_rsp.quot;
		end
		if (state_q == tcp_pkg::S_RESULT && out_free) begin
			rsp_dom_q <= res_dom_q;
			rsp_st_q <= res_st_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_st_q;
	assign rsp.domain = rsp_dom_q;
	assign rsp.tile_count = tcp_pkg::popcount(rsp_dom_q);

	tcp_ram #(.Width(tcp_pkg::TileCount), .Depth(tcp_pkg::MaxCells)) u_dom (
		.clk(clk), .we(dom_we), .waddr(dom_waddr), .wdata(dom_wdata),
		.raddr(dom_raddr), .rdata(dom_rdata)
	);

	tcp_ram #(.Width(tcp_pkg::CellW), .Depth(tcp_pkg::MaxCells)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_waddr),
		.wdata((state_q == tcp_pkg::S_EVAL) ? cell_q : nb_n),
		.raddr(head_q), .rdata(q_rdata)
	);

	tcp_ram #(.Width(1), .Depth(tcp_pkg::MaxCells)) u_pend (
		.clk(clk), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
		.raddr(nb_n), .rdata(pend_rdata)
	);

	tcp_rules u_rules (
		.clk(clk), .we(rule_we), .wr_dir(req.dir), .wr_tile(req.tile),
		.wdata(req.mask), .rd_dir(rule_rdir), .row(rule_row)
	);

	tcp_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp)
	);

	`TCP_ASSERT(a_count_bound, count_q <= tcp_pkg::CntW'(tcp_pkg::MaxCells))
	`TCP_ASSERT_IMP(a_flush_flag, state_q == tcp_pkg::S_FLUSH_RD, flag_q)
	`TCP_ASSERT_IMP(a_prop_noflag, state_q == tcp_pkg::S_NB, !flag_q)
	`TCP_ASSERT_IMP(a_rsp_src, $rose(rsp_valid_q), $past(state_q == tcp_pkg::S_RESULT))
	`TCP_ASSERT_IMP(a_quot_use, state_q == tcp_pkg::S_NB, q1_q >= z_q)
endmodule

// ----- hdl/tcp_ram.sv -----
`timescale 1ns / 1ps
module tcp_ram #(
	parameter int Width = 16,
	parameter int Depth = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/tcp_rules.sv -----
`timescale 1ns / 1ps
module tcp_rules (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [2:0]                                 wr_dir,
	input  logic [3:0]                                 wr_tile,
	input  tcp_pkg::tmask_t                            wdata,
	input  logic [2:0]                                 rd_dir,
	output logic [tcp_pkg::TileCount-1:0][tcp_pkg::TileCount-1:0] row
);
	logic [tcp_pkg::TileCount-1:0][tcp_pkg::TileCount-1:0] mem [tcp_pkg::DirCount];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_dir][wr_tile] <= wdata;
		end
		row <= mem[rd_dir];
	end
endmodule

// ----- hdl/tcp_div.sv -----
`timescale 1ns / 1ps
module tcp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tcp_pkg::div_req_t req,
	output tcp_pkg::div_rsp_t rsp
);
	logic                        busy_q;
	logic                        done_q;
	logic [tcp_pkg::StepW-1:0]   step_q;
	tcp_pkg::cell_t              quo_q;
	logic [tcp_pkg::DimW:0]      rem_q;
	tcp_pkg::dim_t               dvs_q;
	logic [tcp_pkg::DimW:0]      trial;
	logic                        fits;

	always_comb begin
		trial = {rem_q[tcp_pkg::DimW-1:0], quo_q[tcp_pkg::CellW-1]};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == tcp_pkg::StepW'(tcp_pkg::CellW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[tcp_pkg::CellW-2:0], fits};
			rem_q <= fits ? trial - {1'b0, dvs_q} : trial;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q[tcp_pkg::CellW-1:0];
endmodule
